/* rtl/core/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared constants and types for the pointer frame parser: header bytes,
// frame positions, payload slot layout and the result beat.
// ----------------------------------------------------------------------------
package mfp_pkg;

    // header bytes of a frame
    localparam logic [7:0] HDR_FIRST  = 8'hA5;
    localparam logic [7:0] HDR_SECOND = 8'h5A;

    // frame geometry
    localparam int FRAME_BYTES = 10;
    localparam int PAYLOAD_LEN = 7;
    localparam int POS_W       = 4;
    localparam int PAY_IDX_W   = 3;
    localparam int BUTTON_W    = 3;

    // frame positions (index of the next expected byte)
    localparam logic [POS_W-1:0] POS_HUNT      = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR2      = 4'd1;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_PAY_LAST  = 4'd8;
    localparam logic [POS_W-1:0] POS_CHECK     = 4'd9;

    // payload slot layout
    localparam logic [PAY_IDX_W-1:0] IDX_SEQ   = 3'd0;
    localparam logic [PAY_IDX_W-1:0] IDX_BTN   = 3'd1;
    localparam logic [PAY_IDX_W-1:0] IDX_DX_LO = 3'd2;
    localparam logic [PAY_IDX_W-1:0] IDX_DX_HI = 3'd3;
    localparam logic [PAY_IDX_W-1:0] IDX_DY_LO = 3'd4;
    localparam logic [PAY_IDX_W-1:0] IDX_DY_HI = 3'd5;
    localparam logic [PAY_IDX_W-1:0] IDX_WHEEL = 3'd6;

    typedef logic [7:0] t_byte;

    // one decoded frame
    typedef struct packed {
        logic                frame_good;
        logic [7:0]          seq_number;
        logic [BUTTON_W-1:0] button_bits;
        logic signed [15:0]  delta_x;
        logic signed [15:0]  delta_y;
        logic signed [7:0]   wheel_delta;
        logic [15:0]         bad_frame_total;
    } t_mfp_result;

endpackage

/* rtl/core/mfp_if.sv */
// ----------------------------------------------------------------------------
// mfp interfaces
// Valid/ready channels of the parser: received bytes in, decoded frames out.
// ----------------------------------------------------------------------------
interface mfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfp_result_if;
    logic               valid;
    logic               ready;
    logic               frame_good;
    logic [7:0]         seq_number;
    logic [2:0]         button_bits;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  wheel_delta;
    logic [15:0]        bad_frame_total;

    modport source (
        output valid, output frame_good, output seq_number, output button_bits,
        output delta_x, output delta_y, output wheel_delta, output bad_frame_total,
        input ready
    );
    modport sink (
        input valid, input frame_good, input seq_number, input button_bits,
        input delta_x, input delta_y, input wheel_delta, input bad_frame_total,
        output ready
    );
endinterface

/* rtl/core/mfp_parse.sv */
// ----------------------------------------------------------------------------
// mfp_parse
// Frame tracker: header hunt, running checksum, payload slots and the bad
// checksum counter. Builds the decoded frame when the checksum byte arrives.
// ----------------------------------------------------------------------------
module mfp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  mfp_pkg::t_byte       i_byte,
    output logic                 o_result_valid,
    output mfp_pkg::t_mfp_result o_result
);
    import mfp_pkg::*;

    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    t_byte                r_sum;
    t_byte                n_sum;
    logic [15:0]          r_bad;
    logic [15:0]          n_bad;
    t_byte                r_pay [PAYLOAD_LEN];
    logic [PAY_IDX_W-1:0] pay_off;
    logic                 pay_wr;
    logic                 sum_ok;

    assign pay_off = PAY_IDX_W'(r_pos - POS_PAY_FIRST);
    assign pay_wr  = i_step && (r_pos >= POS_PAY_FIRST) && (r_pos <= POS_PAY_LAST);
    assign sum_ok  = (i_byte == r_sum);

    // next position, sum and counter, plus the frame result
    always_comb begin
        n_pos          = r_pos;
        n_sum          = r_sum;
        n_bad          = r_bad;
        o_result_valid = 1'b0;
        o_result       = '0;
        if (r_pos == POS_HUNT || r_pos > POS_CHECK) begin
            if (i_byte == HDR_FIRST) begin
                n_pos = POS_HDR2;
                n_sum = HDR_FIRST;
            end else begin
                n_pos = POS_HUNT;
                n_sum = '0;
            end
        end else if (r_pos == POS_HDR2) begin
            if (i_byte == HDR_SECOND) begin
                n_pos = POS_PAY_FIRST;
                n_sum = r_sum + i_byte;
            end else if (i_byte == HDR_FIRST) begin
                n_pos = POS_HDR2;
                n_sum = HDR_FIRST;
            end else begin
                n_pos = POS_HUNT;
                n_sum = '0;
            end
        end else if (r_pos != POS_CHECK) begin
            n_pos = r_pos + 1'b1;
            n_sum = r_sum + i_byte;
        end else begin
            // checksum byte closes the frame
            n_pos          = POS_HUNT;
            n_sum          = '0;
            o_result_valid = i_step;
            if (sum_ok) begin
                o_result.frame_good  = 1'b1;
                o_result.seq_number  = r_pay[IDX_SEQ];
                o_result.button_bits = r_pay[IDX_BTN][BUTTON_W-1:0];
                o_result.delta_x     = {r_pay[IDX_DX_HI], r_pay[IDX_DX_LO]};
                o_result.delta_y     = {r_pay[IDX_DY_HI], r_pay[IDX_DY_LO]};
                o_result.wheel_delta = r_pay[IDX_WHEEL];
            end else begin
                n_bad = r_bad + 16'd1;
            end
            o_result.bad_frame_total = n_bad;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= '0;
            r_bad <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_bad <= n_bad;
        end
    end

    // payload slots, one per frame byte between header and checksum
    for (genvar gi = 0; gi < PAYLOAD_LEN; gi++) begin : g_pay
        always_ff @(posedge i_clk) begin
            if (pay_wr && pay_off == PAY_IDX_W'(gi)) begin
                r_pay[gi] <= i_byte;
            end
        end
    end

endmodule

/* rtl/core/mfp_out_reg.sv */
// ----------------------------------------------------------------------------
// mfp_out_reg
// Result register: holds one decoded frame until the sink takes the beat.
// ----------------------------------------------------------------------------
module mfp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mfp_pkg::t_mfp_result i_result,
    output logic                 o_free,
    mfp_result_if.source         o_res
);
    import mfp_pkg::*;

    logic        r_valid;
    t_mfp_result r_result;

    // slot is free when empty or being drained this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    // drive the output beat
    assign o_res.valid           = r_valid;
    assign o_res.frame_good      = r_result.frame_good;
    assign o_res.seq_number      = r_result.seq_number;
    assign o_res.button_bits     = r_result.button_bits;
    assign o_res.delta_x         = r_result.delta_x;
    assign o_res.delta_y         = r_result.delta_y;
    assign o_res.wheel_delta     = r_result.wheel_delta;
    assign o_res.bad_frame_total = r_result.bad_frame_total;

endmodule

/* rtl/core/mouse_frame_parser.sv */
// ----------------------------------------------------------------------------
// mouse_frame_parser
// Byte-serial decoder for 10-byte pointer frames (A5 5A header, checksum).
// ----------------------------------------------------------------------------
// Takes one received byte per clock and emits one beat per completed frame
// on the result channel. A byte goes into an input register, the frame
// tracker works on it once the result register is free, and a finished frame
// is loaded into the result register at the end of that cycle; a frame result
// thus passes both registers before it is offered. The input side keeps taking
// bytes while a result waits; it stalls only when both the input register and
// the result register are full and the result sink holds ready low.
// Bad-checksum beats carry zero fields and the updated 16-bit wrapping
// failure count.
module mouse_frame_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfp_byte_if.sink     i_rx,
    mfp_result_if.source o_res
);
    import mfp_pkg::*;

    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        out_free;
    logic        step;
    logic        res_valid;
    t_mfp_result res;

    // input register
    assign i_rx.ready = !r_in_valid || out_free;
    assign step       = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame tracker
    mfp_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_in_byte),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // result register
    mfp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_res    (o_res)
    );

endmodule

/* rtl/core/mfp_checker.sv */
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks on the frame parser's result channel, bound to the top.
// ----------------------------------------------------------------------------
module mfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_frame_good,
    input logic [7:0]  i_seq_number,
    input logic [2:0]  i_button_bits,
    input logic [15:0] i_delta_x,
    input logic [15:0] i_delta_y,
    input logic [7:0]  i_wheel_delta,
    input logic [15:0] i_bad_frame_total
);
    logic [15:0] r_last_total;
    logic        beat;

    assign beat = i_valid && i_ready;

    // failure count seen on the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
        end else if (beat) begin
            r_last_total <= i_bad_frame_total;
        end
    end

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // stalled beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_bad_frame_total))
        else $error("stalled result beat changed");

    // bad frames carry zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_frame_good |-> i_seq_number == 8'd0 && i_button_bits == 3'd0
            && i_delta_x == 16'd0 && i_delta_y == 16'd0 && i_wheel_delta == 8'd0)
        else $error("bad frame with nonzero fields");

    // failure count moves by one per bad frame only
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |-> (i_frame_good && i_bad_frame_total == r_last_total)
            || (!i_frame_good && i_bad_frame_total == r_last_total + 16'd1))
        else $error("bad frame count out of step");

endmodule

bind mouse_frame_parser mfp_checker u_mfp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_res.valid),
    .i_ready           (o_res.ready),
    .i_frame_good      (o_res.frame_good),
    .i_seq_number      (o_res.seq_number),
    .i_button_bits     (o_res.button_bits),
    .i_delta_x         (o_res.delta_x),
    .i_delta_y         (o_res.delta_y),
    .i_wheel_delta     (o_res.wheel_delta),
    .i_bad_frame_total (o_res.bad_frame_total)
);

/* tb/mouse_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// mouse_frame_parser_tb
// Self-checking bench for the pointer frame parser. A short table of directed
// bytes (hunting noise, a broken header, a bad-checksum frame, a repeated
// header byte with all-ones payload) is followed by random frames, mostly
// well formed, mixed with noise, broken headers and cut-off frames. Every
// accepted byte runs through a local frame decoder, and every result beat is
// checked field by field against the oldest expected frame. Both channels
// idle at random, with one calm window and one long result stall.
// ----------------------------------------------------------------------------
module mouse_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfp_pkg::*;

    localparam int TARGET_BYTES   = 1450;
    localparam int IDLE_PCT       = 34;
    localparam int CALM_FROM      = 800;
    localparam int CALM_TO        = 1300;
    localparam int HOLD_AT        = 1500;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    logic clk;
    logic rst_n;

    mfp_byte_if   rx_chan ();
    mfp_result_if res_chan ();

    mouse_frame_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_chan),
        .o_res   (res_chan)
    );

    // byte stream, with a typed frame where a row carries one
    t_byte       rx_stream[$];
    bit          row_known[$];
    t_mfp_result row_beat[$];

    // frames still owed by the block
    t_mfp_result frames_due[$];

    // local copy of the decoder state
    logic [POS_W-1:0] frame_pos = POS_HUNT;
    t_byte            frame_sum = '0;
    t_byte            payload[PAYLOAD_LEN];
    logic [15:0]      bad_total = '0;

    int taken      = 0;
    int mismatches = 0;
    int cycles     = 0;

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // walk one byte through the frame decoder, returns 1 when a frame ends
    function automatic bit decode_byte(input t_byte b, output t_mfp_result beat);
        beat = '0;
        if (frame_pos == POS_HUNT || frame_pos >= FRAME_BYTES) begin
            if (b == HDR_FIRST) begin
                frame_pos = POS_HDR2;
                frame_sum = HDR_FIRST;
            end else begin
                frame_pos = POS_HUNT;
                frame_sum = '0;
            end
            return 1'b0;
        end
        if (frame_pos == POS_HDR2) begin
            if (b == HDR_SECOND) begin
                frame_sum = frame_sum + b;
                frame_pos = POS_PAY_FIRST;
            end else if (b == HDR_FIRST) begin
                frame_pos = POS_HDR2;
                frame_sum = HDR_FIRST;
            end else begin
                frame_pos = POS_HUNT;
                frame_sum = '0;
            end
            return 1'b0;
        end
        if (frame_pos <= POS_PAY_LAST) begin
            payload[frame_pos - POS_PAY_FIRST] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end
        // checksum byte
        if (b == frame_sum) begin
            beat.frame_good  = 1'b1;
            beat.seq_number  = payload[IDX_SEQ];
            beat.button_bits = payload[IDX_BTN][BUTTON_W-1:0];
            beat.delta_x     = {payload[IDX_DX_HI], payload[IDX_DX_LO]};
            beat.delta_y     = {payload[IDX_DY_HI], payload[IDX_DY_LO]};
            beat.wheel_delta = payload[IDX_WHEEL];
        end else begin
            bad_total = bad_total + 1'b1;
        end
        beat.bad_frame_total = bad_total;
        frame_pos = POS_HUNT;
        frame_sum = '0;
        return 1'b1;
    endfunction

    task automatic queue_byte(input t_byte b, input bit known = 1'b0,
                              input t_mfp_result beat = '0);
        rx_stream.push_back(b);
        row_known.push_back(known);
        row_beat.push_back(beat);
    endtask

    // random byte leaning toward the extremes
    function automatic t_byte pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return t_byte'($urandom_range(255));
        endcase
    endfunction

    // header, random payload and, for a full payload, a right or wrong checksum
    task automatic queue_frame(input bit sum_ok, input int payload_bytes);
        t_byte sum;
        t_byte b;
        sum = HDR_FIRST + HDR_SECOND;
        queue_byte(HDR_FIRST);
        queue_byte(HDR_SECOND);
        for (int i = 0; i < payload_bytes; i++) begin
            b = pick_byte();
            sum = sum + b;
            queue_byte(b);
        end
        if (payload_bytes == PAYLOAD_LEN)
            queue_byte(sum_ok ? sum : sum + t_byte'($urandom_range(255, 1)));
    endtask

    // stimulus, reset and byte source
    initial begin : byte_source
        int  sent;
        int  own_cycle;
        int  pick;
        bit  took;
        bit  calm;

        rx_chan.valid   <= 1'b0;
        rx_chan.rx_byte <= '0;
        rst_n           <= 1'b0;
        sent      = 0;
        own_cycle = 0;

        // directed: dropped bytes while hunting, wrong second header byte
        queue_byte(8'h00);
        queue_byte(HDR_SECOND);
        queue_byte(HDR_FIRST);
        queue_byte(8'h00);
        // all-zero payload, checksum 00 against a sum of FF
        queue_byte(HDR_FIRST);
        queue_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) queue_byte(8'h00);
        queue_byte(8'h00, 1'b1, '{frame_good: 1'b0, seq_number: 8'h00,
                   button_bits: 3'd0, delta_x: 16'sd0, delta_y: 16'sd0,
                   wheel_delta: 8'sd0, bad_frame_total: 16'd1});
        // repeated first header byte, all-ones payload
        queue_byte(HDR_FIRST);
        queue_byte(HDR_FIRST);
        queue_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) queue_byte(8'hFF);
        queue_byte(8'hF8, 1'b1, '{frame_good: 1'b1, seq_number: 8'hFF,
                   button_bits: 3'd7, delta_x: -16'sd1, delta_y: -16'sd1,
                   wheel_delta: -8'sd1, bad_frame_total: 16'd1});

        // random: mostly frames, some noise and broken sequences
        while (rx_stream.size() < TARGET_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_frame(1'b1, PAYLOAD_LEN);
            end else if (pick < 82) begin
                queue_frame(1'b0, PAYLOAD_LEN);
            end else if (pick < 90) begin
                repeat ($urandom_range(3, 1)) queue_byte(t_byte'($urandom_range(255)));
            end else if (pick < 95) begin
                queue_byte(HDR_FIRST);
                if ($urandom_range(1)) begin
                    queue_frame(1'b1, PAYLOAD_LEN);
                end else begin
                    queue_byte(t_byte'($urandom_range(HDR_SECOND - 1)));
                end
            end else begin
                queue_frame(1'b1, $urandom_range(PAYLOAD_LEN - 1));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // offer bytes, holding each until it is taken
        while (sent < rx_stream.size()) begin
            @(posedge clk);
            own_cycle++;
            took = rx_chan.valid && rx_chan.ready;
            if (took) sent++;
            calm = own_cycle >= CALM_FROM && own_cycle < CALM_TO;
            if (sent == rx_stream.size()) begin
                rx_chan.valid <= 1'b0;
            end else if (rx_chan.valid && !took) begin
                // beat still pending
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
                rx_chan.valid <= 1'b0;
            end else begin
                rx_chan.valid   <= 1'b1;
                rx_chan.rx_byte <= rx_stream[sent];
            end
        end

        // wait for every owed frame, then a short drain
        @(posedge clk);
        while (frames_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result sink with random stalls, a calm window and one long hold-off
    initial begin : result_sink
        int own_cycle;
        int hold_left;
        own_cycle = 0;
        hold_left = 0;
        res_chan.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            own_cycle++;
            if (own_cycle == HOLD_AT) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                res_chan.ready <= 1'b0;
            end else if (own_cycle >= CALM_FROM && own_cycle < CALM_TO) begin
                res_chan.ready <= 1'b1;
            end else begin
                res_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // predict on accepted bytes, check result beats in order
    always @(posedge clk) begin : frame_check
        t_mfp_result beat;
        t_mfp_result want;
        t_mfp_result got;
        bit          done;
        if (rst_n) begin
            if (rx_chan.valid && rx_chan.ready) begin
                done = decode_byte(rx_chan.rx_byte, beat);
                if (row_known[taken]) frames_due.push_back(row_beat[taken]);
                else if (done) frames_due.push_back(beat);
                taken++;
            end
            if (res_chan.valid && res_chan.ready) begin
                got.frame_good      = res_chan.frame_good;
                got.seq_number      = res_chan.seq_number;
                got.button_bits     = res_chan.button_bits;
                got.delta_x         = res_chan.delta_x;
                got.delta_y         = res_chan.delta_y;
                got.wheel_delta     = res_chan.wheel_delta;
                got.bad_frame_total = res_chan.bad_frame_total;
                if (frames_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected frame beat: good=%0b seq=%02h btn=%0d dx=%0d dy=%0d wheel=%0d bad=%0d",
                                 got.frame_good, got.seq_number, got.button_bits,
                                 got.delta_x, got.delta_y, got.wheel_delta,
                                 got.bad_frame_total);
                end else begin
                    want = frames_due.pop_front();
                    if (got.frame_good      !== want.frame_good  ||
                        got.seq_number      !== want.seq_number  ||
                        got.button_bits     !== want.button_bits ||
                        got.delta_x         !== want.delta_x     ||
                        got.delta_y         !== want.delta_y     ||
                        got.wheel_delta     !== want.wheel_delta ||
                        got.bad_frame_total !== want.bad_frame_total) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("frame mismatch, expected: good=%0b seq=%02h btn=%0d dx=%0d dy=%0d wheel=%0d bad=%0d",
                                     want.frame_good, want.seq_number, want.button_bits,
                                     want.delta_x, want.delta_y, want.wheel_delta,
                                     want.bad_frame_total);
                            $display("                  actual: good=%0b seq=%02h btn=%0d dx=%0d dy=%0d wheel=%0d bad=%0d",
                                     got.frame_good, got.seq_number, got.button_bits,
                                     got.delta_x, got.delta_y, got.wheel_delta,
                                     got.bad_frame_total);
                        end
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

/* files.f */
rtl/core/mfp_pkg.sv
rtl/core/mfp_if.sv
rtl/core/mfp_parse.sv
rtl/core/mfp_out_reg.sv
rtl/core/mouse_frame_parser.sv
rtl/core/mfp_checker.sv
tb/mouse_frame_parser_tb.sv
